// ===== src/atl_pkg.sv =====
// Package for the assembly token lexer: scan state, token record, codes and
// character constants. No dependencies; used by every other file.
package atl_pkg;

   localparam int LEXEME_CAPACITY = 9;
   localparam int LEXEME_LIMIT_INT = (LEXEME_CAPACITY - 1 < 8) ? LEXEME_CAPACITY - 1 : 8;
   localparam logic [3:0] LEXEME_LIMIT = 4'(LEXEME_LIMIT_INT);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int FIFO_COUNT_WIDTH = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] REGISTER_COUNT_RESET = 8'd16;

   localparam logic [3:0] KIND_NUMBER = 4'd0;
   localparam logic [3:0] KIND_ADDRESS = 4'd1;
   localparam logic [3:0] KIND_COLON = 4'd2;
   localparam logic [3:0] KIND_COMMA = 4'd3;
   localparam logic [3:0] KIND_EOL = 4'd4;
   localparam logic [3:0] KIND_EOS = 4'd5;
   localparam logic [3:0] KIND_IDENT = 4'd6;
   localparam logic [3:0] KIND_REGISTER = 4'd7;
   localparam logic [3:0] KIND_ERROR = 4'd8;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_NUMBER_LONG = 3'd1;
   localparam logic [2:0] ERR_IDENT_LONG = 3'd2;
   localparam logic [2:0] ERR_BAD_REGISTER = 3'd3;
   localparam logic [2:0] ERR_NO_DIGIT = 3'd4;
   localparam logic [2:0] ERR_UNMATCHED = 3'd5;

   localparam logic [1:0] BASE_DEC = 2'd0;
   localparam logic [1:0] BASE_BIN = 2'd1;
   localparam logic [1:0] BASE_HEX = 2'd2;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE = 8'h31;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;
   localparam logic [7:0] CHAR_AT = 8'h40;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_B = 8'h62;
   localparam logic [7:0] CHAR_R = 8'h72;
   localparam logic [7:0] CHAR_X = 8'h78;

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_COMMENT = 5'b00010,
      MODE_HASH    = 5'b00100,
      MODE_NUMBER  = 5'b01000,
      MODE_IDENT   = 5'b10000
   } scan_mode_type;

   typedef struct packed {
      scan_mode_type mode;
      logic [1:0]    base;
      logic          is_address;
      logic [31:0]   value;
      logic [63:0]   text;
      logic [3:0]    length;
      logic          reg_shape;
      logic [31:0]   line;
      logic [15:0]   column;
   } scan_state_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [62:0] value;
      logic [63:0] text;
      logic [3:0]  length;
      logic [2:0]  err_code;
      logic [31:0] line;
      logic [15:0] column;
      logic        last;
   } token_type;

endpackage

// ===== src/atl_scan.sv =====
// Per-character scan step: next scan state and up to two tokens.
// Depends on atl_pkg.
module atl_scan (
   input  atl_pkg::scan_state_type state_now,
   input  logic [7:0]              char_code,
   input  logic [7:0]              register_count,
   output atl_pkg::scan_state_type state_next,
   output atl_pkg::token_type      token_first,
   output atl_pkg::token_type      token_second,
   output logic [1:0]              token_count
);

   function automatic atl_pkg::token_type make_token(
      input logic [3:0]  kind,
      input logic [62:0] value,
      input logic [63:0] text,
      input logic [3:0]  length,
      input logic [2:0]  err_code,
      input logic [31:0] line,
      input logic [15:0] column
   );
      atl_pkg::token_type t;
      t.kind = kind;
      t.value = value;
      t.text = text;
      t.length = length;
      t.err_code = err_code;
      t.line = line;
      t.column = column;
      t.last = 1'b0;
      return t;
   endfunction

   logic        is_alpha;
   logic        is_dec;
   logic        is_ident_char;
   logic        is_hex_letter;
   logic        digit_ok;
   logic [3:0]  digit_val;
   logic [31:0] line_adv;
   logic [15:0] col_adv;
   logic [31:0] acc_scaled;
   logic [31:0] acc_next;
   logic [63:0] text_app;
   logic [3:0]  len_inc;
   logic        reg_bad;
   logic        len_full;

   atl_pkg::scan_state_type fresh_state;
   atl_pkg::scan_state_type idle_state;
   atl_pkg::token_type      idle_tok;
   logic                    idle_tok_v;
   atl_pkg::token_type      fin_tok;
   logic                    fin_v;
   atl_pkg::token_type      slot_tok;
   logic                    slot_v;

   assign is_alpha = (char_code >= 8'h61 && char_code <= 8'h7A)
                  || (char_code >= 8'h41 && char_code <= 8'h5A);
   assign is_dec = char_code >= atl_pkg::CHAR_ZERO && char_code <= 8'h39;
   assign is_ident_char = is_alpha || is_dec || char_code == atl_pkg::CHAR_UNDERSCORE;
   assign is_hex_letter = (char_code >= 8'h61 && char_code <= 8'h66)
                       || (char_code >= 8'h41 && char_code <= 8'h46);
   assign len_full = state_now.length >= atl_pkg::LEXEME_LIMIT;

   always_comb begin
      digit_val = char_code[3:0];
      digit_ok = is_dec;
      if (state_now.base == atl_pkg::BASE_BIN) begin
         digit_ok = char_code == atl_pkg::CHAR_ZERO || char_code == atl_pkg::CHAR_ONE;
      end else if (state_now.base == atl_pkg::BASE_HEX && is_hex_letter) begin
         digit_ok = 1'b1;
         digit_val = char_code[3:0] + 4'd9;
      end
   end

   always_comb begin
      case (state_now.base)
         atl_pkg::BASE_BIN: acc_scaled = {state_now.value[30:0], 1'b0};
         atl_pkg::BASE_HEX: acc_scaled = {state_now.value[27:0], 4'b0000};
         default:           acc_scaled = {state_now.value[28:0], 3'b000}
                                        + {state_now.value[30:0], 1'b0};
      endcase
      acc_next = acc_scaled + {28'd0, digit_val};
   end

   always_comb begin
      text_app = state_now.text;
      for (int i = 0; i < 8; i++) begin
         if (state_now.length[2:0] == 3'(i)) begin
            text_app[i*8 +: 8] = state_now.text[i*8 +: 8] | char_code;
         end
      end
      len_inc = state_now.length + 4'd1;
   end

   always_comb begin
      line_adv = state_now.line;
      col_adv = (state_now.column == 16'hFFFF) ? state_now.column : state_now.column + 16'd1;
      if (char_code == atl_pkg::CHAR_NEWLINE) begin
         if (state_now.line != 32'hFFFF_FFFF) begin
            line_adv = state_now.line + 32'd1;
         end
         col_adv = 16'd1;
      end
   end

   always_comb begin
      fresh_state.mode = atl_pkg::MODE_IDLE;
      fresh_state.base = atl_pkg::BASE_DEC;
      fresh_state.is_address = 1'b0;
      fresh_state.value = 32'd0;
      fresh_state.text = 64'd0;
      fresh_state.length = 4'd0;
      fresh_state.reg_shape = 1'b0;
      fresh_state.line = line_adv;
      fresh_state.column = col_adv;
   end

   always_comb begin
      idle_state = fresh_state;
      idle_tok_v = 1'b1;
      idle_tok = make_token(atl_pkg::KIND_ERROR, 63'd0, 64'd0, 4'd0, atl_pkg::ERR_UNMATCHED,
                            line_adv, col_adv);
      unique case (char_code)
         atl_pkg::CHAR_SPACE, atl_pkg::CHAR_TAB: idle_tok_v = 1'b0;
         atl_pkg::CHAR_SEMI: begin
            idle_tok_v = 1'b0;
            idle_state.mode = atl_pkg::MODE_COMMENT;
         end
         atl_pkg::CHAR_HASH: begin
            idle_tok_v = 1'b0;
            idle_state.mode = atl_pkg::MODE_HASH;
         end
         atl_pkg::CHAR_AT: begin
            idle_tok_v = 1'b0;
            idle_state.mode = atl_pkg::MODE_NUMBER;
            idle_state.base = atl_pkg::BASE_HEX;
            idle_state.is_address = 1'b1;
         end
         atl_pkg::CHAR_COLON:   idle_tok.kind = atl_pkg::KIND_COLON;
         atl_pkg::CHAR_COMMA:   idle_tok.kind = atl_pkg::KIND_COMMA;
         atl_pkg::CHAR_NEWLINE: idle_tok.kind = atl_pkg::KIND_EOL;
         atl_pkg::CHAR_NUL:     idle_tok.kind = atl_pkg::KIND_EOS;
         default: begin
            if (is_alpha || char_code == atl_pkg::CHAR_UNDERSCORE) begin
               idle_tok_v = 1'b0;
               idle_state.mode = atl_pkg::MODE_IDENT;
               idle_state.reg_shape = char_code == atl_pkg::CHAR_R;
               idle_state.text = {56'd0, char_code};
               idle_state.length = 4'd1;
            end
         end
      endcase
      if (idle_tok.kind != atl_pkg::KIND_ERROR) begin
         idle_tok.err_code = atl_pkg::ERR_NONE;
      end
   end

   assign reg_bad = state_now.value >= {24'd0, register_count};

   always_comb begin
      state_next = state_now;
      state_next.line = line_adv;
      state_next.column = col_adv;
      fin_v = 1'b0;
      fin_tok = make_token(atl_pkg::KIND_IDENT, 63'd0, state_now.text, state_now.length,
                           atl_pkg::ERR_NONE, state_now.line, state_now.column);
      slot_v = 1'b0;
      slot_tok = idle_tok;
      unique case (state_now.mode)
         atl_pkg::MODE_COMMENT: begin
            if (char_code == atl_pkg::CHAR_NEWLINE || char_code == atl_pkg::CHAR_NUL) begin
               state_next = idle_state;
               slot_v = idle_tok_v;
            end
         end
         atl_pkg::MODE_HASH: begin
            if (char_code == atl_pkg::CHAR_X || char_code == atl_pkg::CHAR_B) begin
               state_next.mode = atl_pkg::MODE_NUMBER;
               state_next.base = (char_code == atl_pkg::CHAR_X) ? atl_pkg::BASE_HEX
                                                                 : atl_pkg::BASE_BIN;
            end else if (is_dec) begin
               state_next.mode = atl_pkg::MODE_NUMBER;
               state_next.base = atl_pkg::BASE_DEC;
               state_next.value = acc_next;
               state_next.text = text_app;
               state_next.length = len_inc;
            end else begin
               state_next = fresh_state;
               slot_v = 1'b1;
               slot_tok = make_token(atl_pkg::KIND_ERROR, 63'd0, 64'd0, 4'd0,
                                     atl_pkg::ERR_NO_DIGIT, line_adv, col_adv);
            end
         end
         atl_pkg::MODE_NUMBER: begin
            if (digit_ok) begin
               if (len_full) begin
                  state_next = fresh_state;
                  slot_v = 1'b1;
                  slot_tok = make_token(atl_pkg::KIND_ERROR, 63'd0, state_now.text,
                                        state_now.length, atl_pkg::ERR_NUMBER_LONG,
                                        line_adv, col_adv);
               end else begin
                  state_next.value = acc_next;
                  state_next.text = text_app;
                  state_next.length = len_inc;
               end
            end else begin
               fin_v = 1'b1;
               fin_tok.kind = state_now.is_address ? atl_pkg::KIND_ADDRESS
                                                   : atl_pkg::KIND_NUMBER;
               fin_tok.value = {31'd0, state_now.value};
               state_next = idle_state;
               slot_v = idle_tok_v;
            end
         end
         atl_pkg::MODE_IDENT: begin
            if (is_ident_char) begin
               if (len_full) begin
                  state_next = fresh_state;
                  slot_v = 1'b1;
                  slot_tok = make_token(atl_pkg::KIND_ERROR, 63'd0, state_now.text,
                                        state_now.length, atl_pkg::ERR_IDENT_LONG,
                                        line_adv, col_adv);
               end else begin
                  state_next.reg_shape = state_now.reg_shape && is_dec;
                  state_next.value = acc_next;
                  state_next.text = text_app;
                  state_next.length = len_inc;
               end
            end else begin
               fin_v = 1'b1;
               if (state_now.reg_shape) begin
                  if (reg_bad) begin
                     fin_tok.kind = atl_pkg::KIND_ERROR;
                     fin_tok.err_code = atl_pkg::ERR_BAD_REGISTER;
                  end else begin
                     fin_tok.kind = atl_pkg::KIND_REGISTER;
                     fin_tok.value = {31'd0, state_now.value};
                  end
               end
               state_next = idle_state;
               slot_v = idle_tok_v;
            end
         end
         default: begin
            state_next = idle_state;
            slot_v = idle_tok_v;
         end
      endcase
   end

   always_comb begin
      if (fin_v) begin
         token_first = fin_tok;
         token_first.last = !slot_v;
         token_second = slot_tok;
         token_second.last = 1'b1;
         token_count = slot_v ? 2'd2 : 2'd1;
      end else begin
         token_first = slot_tok;
         token_first.last = 1'b1;
         token_second = slot_tok;
         token_count = slot_v ? 2'd1 : 2'd0;
      end
   end

endmodule

// ===== src/atl_token_fifo.sv =====
// Four-entry token queue taking up to two items per cycle and giving one.
// Depends on atl_pkg.
module atl_token_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         push_count,
   input  atl_pkg::token_type push_first,
   input  atl_pkg::token_type push_second,
   input  logic               pop,
   output atl_pkg::token_type head_token,
   output logic               not_empty,
   output logic               room_for_two
);

   atl_pkg::token_type entries_ff [atl_pkg::FIFO_DEPTH];

   logic [atl_pkg::FIFO_PTR_WIDTH-1:0]   head_ff, head_in;
   logic [atl_pkg::FIFO_PTR_WIDTH-1:0]   tail_ff, tail_in;
   logic [atl_pkg::FIFO_PTR_WIDTH-1:0]   tail_plus_one;
   logic [atl_pkg::FIFO_COUNT_WIDTH-1:0] count_ff, count_in;

   assign tail_plus_one = tail_ff + atl_pkg::FIFO_PTR_WIDTH'(1);

   always_comb begin
      head_in = pop ? head_ff + atl_pkg::FIFO_PTR_WIDTH'(1) : head_ff;
      tail_in = tail_ff + atl_pkg::FIFO_PTR_WIDTH'(push_count);
      count_in = count_ff + atl_pkg::FIFO_COUNT_WIDTH'(push_count)
               - atl_pkg::FIFO_COUNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[tail_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entries_ff[tail_plus_one] <= push_second;
      end
   end

   assign head_token = entries_ff[head_ff];
   assign not_empty = count_ff != '0;
   assign room_for_two = count_ff <= atl_pkg::FIFO_COUNT_WIDTH'(atl_pkg::FIFO_DEPTH - 2);

endmodule

// ===== src/assembly_token_lexer.sv =====
// Assembly token lexer top level: one ASCII character per item in, tokens out.
// A character accepted is registered, then scanned, and its tokens are written into the token queue.
// Throughput: one character per cycle; a character that ends a lexeme and is itself
// a token gives two tokens, one per cycle, and the four-entry token queue sets
// when input stalls. Synchronous reset: idle scan state, line and column 1,
// register count 16, empty queue.
module assembly_token_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic [62:0] rsp_token_value,
   output logic [63:0] rsp_lexeme_text,
   output logic [3:0]  rsp_lexeme_length,
   output logic [2:0]  rsp_error_code,
   output logic [31:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic        rsp_last_of_run,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic       char_valid_ff, char_valid_in;
   logic [7:0] char_ff;
   logic [7:0] reg_count_ff;
   logic       step_fire;
   logic       room_for_two;
   logic [1:0] token_count;
   logic [1:0] push_count;

   atl_pkg::scan_state_type state_ff, state_in, state_reset, state_step;
   atl_pkg::token_type      token_first, token_second, head_token;

   always_comb begin
      state_reset.mode = atl_pkg::MODE_IDLE;
      state_reset.base = atl_pkg::BASE_DEC;
      state_reset.is_address = 1'b0;
      state_reset.value = 32'd0;
      state_reset.text = 64'd0;
      state_reset.length = 4'd0;
      state_reset.reg_shape = 1'b0;
      state_reset.line = 32'd1;
      state_reset.column = 16'd1;
   end

   assign step_fire = char_valid_ff && room_for_two;
   assign req_ready = !char_valid_ff || step_fire;
   assign push_count = step_fire ? token_count : 2'd0;

   always_comb begin
      char_valid_in = char_valid_ff;
      if (req_valid && req_ready) begin
         char_valid_in = 1'b1;
      end else if (step_fire) begin
         char_valid_in = 1'b0;
      end
      state_in = step_fire ? state_step : state_ff;
   end

   atl_scan u_scan (
      .state_now      (state_ff),
      .char_code      (char_ff),
      .register_count (reg_count_ff),
      .state_next     (state_step),
      .token_first    (token_first),
      .token_second   (token_second),
      .token_count    (token_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         char_valid_ff <= 1'b0;
         state_ff <= state_reset;
         reg_count_ff <= atl_pkg::REGISTER_COUNT_RESET;
      end else begin
         char_valid_ff <= char_valid_in;
         state_ff <= state_in;
         if (csr_write_enable) begin
            reg_count_ff <= csr_write_data;
         end
      end
   end

   // hold the character while the queue lacks room
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char_code;
      end
   end

   atl_token_fifo u_token_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_first   (token_first),
      .push_second  (token_second),
      .pop          (rsp_valid && rsp_ready),
      .head_token   (head_token),
      .not_empty    (rsp_valid),
      .room_for_two (room_for_two)
   );

   assign rsp_token_kind = head_token.kind;
   assign rsp_token_value = head_token.value;
   assign rsp_lexeme_text = head_token.text;
   assign rsp_lexeme_length = head_token.length;
   assign rsp_error_code = head_token.err_code;
   assign rsp_line_number = head_token.line;
   assign rsp_column_number = head_token.column;
   assign rsp_last_of_run = head_token.last;

endmodule

// ===== src/atl_checker.sv =====
// Port-level checks for the assembly token lexer, bound to the top level.
// Depends on atl_pkg.
module atl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_token_kind,
   input logic [62:0] rsp_token_value,
   input logic [3:0]  rsp_lexeme_length,
   input logic [2:0]  rsp_error_code,
   input logic [31:0] rsp_line_number,
   input logic [15:0] rsp_column_number
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind)
                                 && $stable(rsp_token_value))
      else $error("item changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_token_kind == atl_pkg::KIND_ERROR) == (rsp_error_code != atl_pkg::ERR_NONE))
      else $error("error code does not match token kind");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind <= atl_pkg::KIND_ERROR
                    && rsp_lexeme_length <= atl_pkg::LEXEME_LIMIT)
      else $error("token kind or lexeme length out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_number != 32'd0 && rsp_column_number != 16'd0)
      else $error("position counter reads zero");

endmodule

bind assembly_token_lexer atl_checker u_atl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_token_kind    (rsp_token_kind),
   .rsp_token_value   (rsp_token_value),
   .rsp_lexeme_length (rsp_lexeme_length),
   .rsp_error_code    (rsp_error_code),
   .rsp_line_number   (rsp_line_number),
   .rsp_column_number (rsp_column_number)
);
